// File: design/bpbt_pkg.sv
// Shared constants, types and helpers for the bad-page bitmap table.
package bpbt_pkg;

    localparam int PAGES_DEF = 1024;
    localparam int MAPS_DEF  = 2;

    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int DIGIT_W   = 8;
    localparam int DIGITS    = WORD_W / DIGIT_W;
    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int POS_W     = $clog2(DIGIT_W);

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_FIND  = 2'd2
    } op_t;

    typedef struct packed {
        logic load;
        logic shift;
    } dig_ctl_t;

    typedef struct packed {
        logic                 hit;
        logic [DIG_IDX_W-1:0] dig;
        logic [POS_W-1:0]     pos;
    } dig_stat_t;

    function automatic logic [POS_W-1:0] first_zero(input logic [DIGIT_W-1:0] d);
        logic [POS_W-1:0] r;
        r = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            if (!d[i]) begin
                r = POS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: design/bpbt_digit_scan.sv
// Digit-serial search for the first good page bit within one bitmap word.
module bpbt_digit_scan import bpbt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dig_ctl_t          ctl,
    input  logic [WORD_W-1:0] word_in,
    output dig_stat_t         stat
);

    logic [WORD_W-1:0]    sh_reg;
    logic [WORD_W-1:0]    sh_next;
    logic [DIG_IDX_W-1:0] dig_reg;
    logic [DIG_IDX_W-1:0] dig_next;

    always_comb begin
        sh_next  = sh_reg;
        dig_next = dig_reg;
        if (ctl.load) begin
            sh_next  = word_in;
            dig_next = '0;
        end else if (ctl.shift) begin
            sh_next  = sh_reg >> DIGIT_W;
            dig_next = dig_reg + DIG_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dig_reg <= '0;
        end else begin
            dig_reg <= dig_next;
        end
        sh_reg <= sh_next;
    end

    assign stat.hit = (sh_reg[DIGIT_W-1:0] != {DIGIT_W{1'b1}});
    assign stat.dig = dig_reg;
    assign stat.pos = first_zero(sh_reg[DIGIT_W-1:0]);

endmodule

// File: design/bad_page_bitmap_table_core.sv
// Top level of the bad-page bitmap table: bitmap memory, control and result register.
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------
//  input    | s_valid / s_ready  | s_op, s_map_select, s_page, s_bad_flag
//  result   | m_valid / m_ready  | m_is_bad, m_found, m_next_page
//
// Mark and query go from accept through ST_MARK or ST_QUERY, then ST_DONE, to the result register;
// the next item is taken back in ST_IDLE. Find scans one 32-bit bitmap word per cycle, then steps
// up to 4 8-bit digits through the digit shift register of the hit word.
// After reset a clearing pass writes every memory word (DEPTH words, 64 at the defaults),
// with s_ready low.
// One item at a time; a finished result waits in the result register while the next is taken.
module bad_page_bitmap_table_core import bpbt_pkg::*; #(
    parameter int PAGES = PAGES_DEF,
    parameter int MAPS  = MAPS_DEF,
    localparam int PW   = $clog2(PAGES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_op,
    input  logic          s_map_select,
    input  logic [PW-1:0] s_page,
    input  logic          s_bad_flag,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_is_bad,
    output logic          m_found,
    output logic [PW-1:0] m_next_page
);

    localparam int WPM       = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WB        = (WPM > 1) ? $clog2(WPM) : 1;
    localparam int MW        = (MAPS > 1) ? $clog2(MAPS) : 1;
    localparam int AW        = MW + WB;
    localparam int DEPTH     = 1 << AW;
    localparam int IW        = WB + BIT_W;
    localparam int LAST_WORD = WPM - 1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_DIGIT = 7'b0001000,
        ST_MARK  = 7'b0010000,
        ST_QUERY = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [MW-1:0]     map_reg, map_next;
    logic [WB-1:0]     word_reg, word_next;
    logic [WB-1:0]     start_word_reg, start_word_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [PW-1:0]     page_reg, page_next;
    logic              flag_reg, flag_next;
    logic              inrange_reg, inrange_next;
    logic              res_is_bad_reg, res_is_bad_next;
    logic              res_found_reg, res_found_next;
    logic [PW-1:0]     res_next_reg, res_next_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_is_bad_reg, m_is_bad_next;
    logic              m_found_reg, m_found_next;
    logic [PW-1:0]     m_next_page_reg, m_next_page_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    logic [IW-1:0]     page_ext;
    logic [IW-1:0]     hit_idx;
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] tail_mask;
    logic [WORD_W-1:0] eff_word;
    logic [MW-1:0]     map_in;
    dig_ctl_t          dig_ctl;
    dig_stat_t         dig_stat;

    bpbt_digit_scan u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dig_ctl),
        .word_in (eff_word),
        .stat    (dig_stat)
    );

    assign page_ext = IW'(s_page);
    assign map_in   = (MAPS > 1) ? MW'(s_map_select) : '0;
    assign hit_idx  = {word_reg, dig_stat.dig, dig_stat.pos};
    assign rd_addr  = {map_next, word_next};

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            low_mask[i]  = (word_reg == start_word_reg) && (BIT_W'(i) <= bit_reg);
            tail_mask[i] = (word_reg == WB'(LAST_WORD)) && (LAST_WORD * WORD_W + i >= PAGES);
        end
        eff_word = rd_data_reg | low_mask | tail_mask;
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        map_next         = map_reg;
        word_next        = word_reg;
        start_word_next  = start_word_reg;
        bit_next         = bit_reg;
        page_next        = page_reg;
        flag_next        = flag_reg;
        inrange_next     = inrange_reg;
        res_is_bad_next  = res_is_bad_reg;
        res_found_next   = res_found_reg;
        res_next_next    = res_next_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_is_bad_next    = m_is_bad_reg;
        m_found_next     = m_found_reg;
        m_next_page_next = m_next_page_reg;
        dig_ctl          = '0;
        wr_en            = 1'b0;
        wr_addr          = {map_reg, word_reg};
        wr_data          = rd_data_reg | (WORD_W'(flag_reg) << bit_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    map_next        = map_in;
                    word_next       = page_ext[IW-1:BIT_W];
                    start_word_next = page_ext[IW-1:BIT_W];
                    bit_next        = page_ext[BIT_W-1:0];
                    page_next       = s_page;
                    flag_next       = s_bad_flag;
                    inrange_next    = (s_page <= PW'(PAGES - 1));
                    res_is_bad_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_next_next   = '0;
                    case (s_op)
                        OP_MARK:  state_next = ST_MARK;
                        OP_QUERY: state_next = ST_QUERY;
                        OP_FIND: begin
                            if (s_page >= PW'(PAGES - 1)) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (eff_word != {WORD_W{1'b1}}) begin
                    dig_ctl.load = 1'b1;
                    state_next   = ST_DIGIT;
                end else if (word_reg == WB'(LAST_WORD)) begin
                    state_next = ST_DONE;
                end else begin
                    word_next = word_reg + WB'(1);
                end
            end
            ST_DIGIT: begin
                if (dig_stat.hit) begin
                    res_found_next = 1'b1;
                    res_next_next  = hit_idx[PW-1:0];
                    state_next     = ST_DONE;
                end else begin
                    dig_ctl.shift = 1'b1;
                end
            end
            ST_MARK: begin
                wr_en      = inrange_reg;
                state_next = ST_DONE;
            end
            ST_QUERY: begin
                res_is_bad_next = rd_data_reg[bit_reg] & inrange_reg;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_is_bad_next    = res_is_bad_reg;
                    m_found_next     = res_found_reg;
                    m_next_page_next = res_next_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        map_reg         <= map_next;
        word_reg        <= word_next;
        start_word_reg  <= start_word_next;
        bit_reg         <= bit_next;
        page_reg        <= page_next;
        flag_reg        <= flag_next;
        inrange_reg     <= inrange_next;
        res_is_bad_reg  <= res_is_bad_next;
        res_found_reg   <= res_found_next;
        res_next_reg    <= res_next_next;
        m_is_bad_reg    <= m_is_bad_next;
        m_found_reg     <= m_found_next;
        m_next_page_reg <= m_next_page_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_is_bad    = m_is_bad_reg;
    assign m_found     = m_found_reg;
    assign m_next_page = m_next_page_reg;

`ifndef SYNTHESIS
    a_found_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_found_reg) |-> (res_next_reg > page_reg))
        else $error("found page not above start page");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !res_found_reg) |-> (res_next_reg == '0))
        else $error("next page nonzero without a hit");

    a_digit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT && !dig_stat.hit) |-> (dig_stat.dig != DIG_IDX_W'(DIGITS - 1)))
        else $error("digit scan ran past the word");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (word_reg <= WB'(LAST_WORD)))
        else $error("scan word past end of map");
`endif

endmodule
